>>> hw/rtl/tof_pkg.sv
// Shared widths, reset value and side-band types of the fhan tracking pipeline.
package tof_pkg;

  // field and internal widths
  localparam int HW   = 24;   // step period h, Q0.24
  localparam int XW   = 32;   // position and velocity error, Q16.16
  localparam int RFW  = 31;   // speed factor r, unsigned Q15.16
  localparam int H2W  = 48;   // h^2, Q0.48
  localparam int DW   = 47;   // d = r*h^2, Q.32
  localparam int A0W  = 49;   // a0 = h*x2, signed Q.32
  localparam int YW   = 50;   // y = x1 + a0, signed Q.32
  localparam int TW   = 54;   // d + 8|y|
  localparam int NW   = 102;  // radicand d*(d + 8|y|), Q.64
  localparam int QW   = NW / 2; // square root width
  localparam int REMW = QW + 2; // square root remainder
  localparam int AW   = 52;   // a, signed Q.32
  localparam int NUMW = 78;   // r*|a|
  localparam int QDW  = 31;   // quotient r*|a|/d
  localparam int FW   = 33;   // signed result before the clip

  localparam logic [HW-1:0] STEP_RESET = 24'd838861;
  localparam logic signed [FW-1:0] FH_MAX = 33'sd2147483647;
  localparam logic signed [FW-1:0] FH_MIN = -33'sd2147483648;

  // data that rides along the square root stages
  typedef struct packed {
    logic                  deg;
    logic [RFW-1:0]        r;
    logic [DW-1:0]         d;
    logic [A0W-1:0]        a0;
    logic [YW-1:0]         y;
    logic [YW-1:0]         ym;
  } sq_side_t;

  // data that rides along the divider stages
  typedef struct packed {
    logic                  deg;
    logic [RFW-1:0]        r;
    logic                  inwin;
    logic                  apos;
  } dv_side_t;

endpackage

>>> hw/rtl/tof_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module tof_sqrt import tof_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  in_rad,
  input  sq_side_t       in_side,
  output logic           out_vld,
  output logic [QW-1:0]  out_root,
  output sq_side_t       out_side
);

  localparam int STEPS = NW / 2;

  logic            vld_r  [STEPS];
  logic [NW-1:0]   rad_r  [STEPS];
  logic [REMW-1:0] rem_r  [STEPS];
  logic [QW-1:0]   root_r [STEPS];
  sq_side_t        side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic            vld_in;
    logic [NW-1:0]   rad_in;
    logic [REMW-1:0] rem_in;
    logic [QW-1:0]   root_in;
    sq_side_t        side_in;
    logic [REMW+1:0] cur;
    logic [REMW+1:0] trial;
    logic [REMW-1:0] rem_nxt;
    logic [QW-1:0]   root_nxt;

    // pick up the previous stage, or the pipeline input
    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      cur   = {rem_in, rad_in[NW-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      if (cur >= trial) begin
        rem_nxt  = REMW'(cur - trial);
        root_nxt = {root_in[QW-2:0], 1'b1};
      end else begin
        rem_nxt  = cur[REMW-1:0];
        root_nxt = {root_in[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_in[NW-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_root = root_r[STEPS-1];
  assign out_side = side_r[STEPS-1];

endmodule

>>> hw/rtl/tof_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module tof_div import tof_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [NUMW-1:0] in_num,
  input  logic [DW-1:0]   in_den,
  input  dv_side_t        in_side,
  output logic            out_vld,
  output logic [QDW-1:0]  out_quo,
  output dv_side_t        out_side
);

  logic            vld_r  [QDW];
  logic [QDW-1:0]  low_r  [QDW];
  logic [DW-1:0]   rem_r  [QDW];
  logic [DW-1:0]   den_r  [QDW];
  logic [QDW-1:0]  quo_r  [QDW];
  dv_side_t        side_r [QDW];

  for (genvar k = 0; k < QDW; k++) begin : g_step
    logic           vld_in;
    logic [QDW-1:0] low_in;
    logic [DW-1:0]  rem_in;
    logic [DW-1:0]  den_in;
    logic [QDW-1:0] quo_in;
    dv_side_t       side_in;
    logic [DW:0]    cur;
    logic [DW-1:0]  rem_nxt;
    logic           bit_nxt;

    // the upper numerator bits start below the divisor since the quotient fits
    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign low_in  = in_num[QDW-1:0];
      assign rem_in  = in_num[NUMW-1:QDW];
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign low_in  = low_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
    end

    // shift in one numerator bit, subtract when it fits
    always_comb begin
      cur = {rem_in, low_in[QDW-1]};
      if (cur >= {1'b0, den_in}) begin
        rem_nxt = DW'(cur - {1'b0, den_in});
        bit_nxt = 1'b1;
      end else begin
        rem_nxt = cur[DW-1:0];
        bit_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        low_r[k]  <= {low_in[QDW-2:0], 1'b0};
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        quo_r[k]  <= {quo_in[QDW-2:0], bit_nxt};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[QDW-1];
  assign out_quo  = quo_r[QDW-1];
  assign out_side = side_r[QDW-1];

endmodule

>>> hw/rtl/time_optimal_tracking_fhan.sv
// Throughput: one beat per cycle; the pipeline holds as a whole while the output stalls.
// The depth is set by the 51-stage square root and the 31-stage divider.
// Reset (rst_n low, synchronous) clears all valid bits and loads step_period with 838861.
// Configuration writes take effect for beats accepted in the following cycles.
module time_optimal_tracking_fhan import tof_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,   // step_period
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,      // pos_error[31:0], vel_error[63:32], speed_factor[94:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // accel_cmd[31:0]
  output logic [1:0]  out_tuser      // degenerate[0], saturated[1]
);

  logic en;
  logic [HW-1:0] step_r;

  // hold the step period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_wr_en) begin
      step_r <= cfg_wr_data;
    end
  end

  // advance the whole pipeline unless a finished beat waits at the output
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: h^2 and h*|x2|
  logic           s1_vld_r;
  logic [XW-1:0]  s1_x1_r;
  logic           s1_neg_r;
  logic [RFW-1:0] s1_r_r;
  logic [H2W-1:0] s1_hh_r;
  logic [H2W-1:0] s1_a0m_r;
  logic [XW-1:0]  x2_mag;
  logic [HW+XW-1:0] a0_full;

  always_comb begin
    x2_mag  = in_tdata[63] ? XW'(-in_tdata[63:32]) : in_tdata[63:32];
    a0_full = {{XW{1'b0}}, step_r} * {{HW{1'b0}}, x2_mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x1_r  <= in_tdata[31:0];
      s1_neg_r <= in_tdata[63];
      s1_r_r   <= in_tdata[94:64];
      s1_hh_r  <= {{HW{1'b0}}, step_r} * {{HW{1'b0}}, step_r};
      s1_a0m_r <= a0_full[HW+XW-1:8];
    end
  end

  // stage 2: partial products of r*h^2, signed a0
  logic           s2_vld_r;
  logic [XW-1:0]  s2_x1_r;
  logic [RFW-1:0] s2_r_r;
  logic [RFW+HW-1:0] s2_plo_r;
  logic [RFW+HW-1:0] s2_phi_r;
  logic [A0W-1:0] s2_a0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x1_r  <= s1_x1_r;
      s2_r_r   <= s1_r_r;
      s2_plo_r <= {{HW{1'b0}}, s1_r_r} * {{RFW{1'b0}}, s1_hh_r[HW-1:0]};
      s2_phi_r <= {{HW{1'b0}}, s1_r_r} * {{RFW{1'b0}}, s1_hh_r[H2W-1:HW]};
      s2_a0_r  <= s1_neg_r ? A0W'(-{1'b0, s1_a0m_r}) : {1'b0, s1_a0m_r};
    end
  end

  // stage 3: d = floor(r*h^2) in Q.32, y = x1 + a0
  logic           s3_vld_r;
  logic [RFW-1:0] s3_r_r;
  logic [DW-1:0]  s3_d_r;
  logic [A0W-1:0] s3_a0_r;
  logic [YW-1:0]  s3_y_r;
  logic [RFW+H2W-1:0] rhh;

  assign rhh = {s2_phi_r, {HW{1'b0}}} + {{HW{1'b0}}, s2_plo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r_r  <= s2_r_r;
      s3_d_r  <= rhh[RFW+H2W-1:32];
      s3_a0_r <= s2_a0_r;
      s3_y_r  <= {{2{s2_x1_r[XW-1]}}, s2_x1_r, 16'b0} + {s2_a0_r[A0W-1], s2_a0_r};
    end
  end

  // stage 4: |y|, t = d + 8|y|, zero-d flag
  logic           s4_vld_r;
  sq_side_t       s4_side_r;
  logic [TW-1:0]  s4_t_r;
  logic [YW-1:0]  ym;

  assign ym = s3_y_r[YW-1] ? YW'(-s3_y_r) : s3_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r.deg <= (s3_d_r == '0);
      s4_side_r.r   <= s3_r_r;
      s4_side_r.d   <= s3_d_r;
      s4_side_r.a0  <= s3_a0_r;
      s4_side_r.y   <= s3_y_r;
      s4_side_r.ym  <= ym;
      s4_t_r        <= {{(TW-DW){1'b0}}, s3_d_r} + {1'b0, ym, 3'b000};
    end
  end

  // stage 5: partial products of d*t
  logic           s5_vld_r;
  sq_side_t       s5_side_r;
  logic [50:0]    s5_p00_r;
  logic [50:0]    s5_p01_r;
  logic [49:0]    s5_p10_r;
  logic [49:0]    s5_p11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= s4_side_r;
      s5_p00_r  <= {27'b0, s4_side_r.d[23:0]}  * {24'b0, s4_t_r[26:0]};
      s5_p01_r  <= {27'b0, s4_side_r.d[23:0]}  * {24'b0, s4_t_r[53:27]};
      s5_p10_r  <= {27'b0, s4_side_r.d[46:24]} * {23'b0, s4_t_r[26:0]};
      s5_p11_r  <= {27'b0, s4_side_r.d[46:24]} * {23'b0, s4_t_r[53:27]};
    end
  end

  // stage 6: sum the radicand
  logic           s6_vld_r;
  sq_side_t       s6_side_r;
  logic [NW-1:0]  s6_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_side_r <= s5_side_r;
      s6_rad_r  <= {51'b0, s5_p00_r}
                 + {24'b0, s5_p01_r, 27'b0}
                 + {28'b0, s5_p10_r, 24'b0}
                 + {1'b0, s5_p11_r, 51'b0};
    end
  end

  // square root a1
  logic          sq_vld;
  logic [QW-1:0] sq_root;
  sq_side_t      sq_side;

  tof_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s6_vld_r),
    .in_rad   (s6_rad_r),
    .in_side  (s6_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // stage A: a2 and window select of a
  logic           sa_vld_r;
  logic           sa_deg_r;
  logic [RFW-1:0] sa_r_r;
  logic [DW-1:0]  sa_d_r;
  logic [AW-1:0]  sa_a_r;
  logic [YW-1:0]  half;
  logic [AW-1:0]  hterm;
  logic [AW-1:0]  a0x;
  logic [AW-1:0]  a_nxt;

  always_comb begin
    half = YW'((sq_root - {{(QW-DW){1'b0}}, sq_side.d}) >> 1);
    a0x  = {{(AW-A0W){sq_side.a0[A0W-1]}}, sq_side.a0};
    if (sq_side.y[YW-1]) begin
      hterm = AW'(-{2'b0, half});
    end else if (sq_side.y != '0) begin
      hterm = {2'b0, half};
    end else begin
      hterm = '0;
    end
    if (sq_side.ym < {{(YW-DW){1'b0}}, sq_side.d}) begin
      a_nxt = a0x + {{2{sq_side.y[YW-1]}}, sq_side.y};
    end else begin
      a_nxt = a0x + hterm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else if (en) begin
      sa_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_deg_r <= sq_side.deg;
      sa_r_r   <= sq_side.r;
      sa_d_r   <= sq_side.d;
      sa_a_r   <= a_nxt;
    end
  end

  // stage B: |a|, inner window test, partial products of r*|a|
  logic           sb_vld_r;
  dv_side_t       sb_side_r;
  logic [DW-1:0]  sb_d_r;
  logic [54:0]    sb_plo_r;
  logic [53:0]    sb_phi_r;
  logic [AW-1:0]  am;

  assign am = sa_a_r[AW-1] ? AW'(-sa_a_r) : sa_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= 1'b0;
    end else if (en) begin
      sb_vld_r <= sa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_side_r.deg   <= sa_deg_r;
      sb_side_r.r     <= sa_r_r;
      sb_side_r.inwin <= (am < {{(AW-DW){1'b0}}, sa_d_r});
      sb_side_r.apos  <= !sa_a_r[AW-1] && (sa_a_r != '0);
      sb_d_r          <= sa_d_r;
      sb_plo_r        <= {24'b0, sa_r_r} * {31'b0, am[23:0]};
      sb_phi_r        <= {23'b0, sa_r_r} * {31'b0, am[46:24]};
    end
  end

  // stage C: sum the numerator r*|a|
  logic            sc_vld_r;
  dv_side_t        sc_side_r;
  logic [DW-1:0]   sc_d_r;
  logic [NUMW-1:0] sc_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= 1'b0;
    end else if (en) begin
      sc_vld_r <= sb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_side_r <= sb_side_r;
      sc_d_r    <= sb_d_r;
      sc_num_r  <= {23'b0, sb_plo_r} + {sb_phi_r, 24'b0};
    end
  end

  // quotient r*|a|/d
  logic           dv_vld;
  logic [QDW-1:0] dv_quo;
  dv_side_t       dv_side;

  tof_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sc_vld_r),
    .in_num   (sc_num_r),
    .in_den   (sc_d_r),
    .in_side  (sc_side_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // output register: sign, clip, zero-d override
  logic [FW-1:0]  fmag;
  logic [FW-1:0]  fh;
  logic [31:0]    acc_nxt;
  logic           sat_nxt;
  logic           out_vld_r;
  logic [31:0]    out_acc_r;
  logic           out_deg_r;
  logic           out_sat_r;

  always_comb begin
    fmag = dv_side.inwin ? {2'b0, dv_quo} : {2'b0, dv_side.r};
    fh   = dv_side.apos ? FW'(-fmag) : fmag;
    sat_nxt = 1'b0;
    if ($signed(fh) > FH_MAX) begin
      acc_nxt = FH_MAX[31:0];
      sat_nxt = 1'b1;
    end else if ($signed(fh) < FH_MIN) begin
      acc_nxt = FH_MIN[31:0];
      sat_nxt = 1'b1;
    end else begin
      acc_nxt = fh[31:0];
    end
    if (dv_side.deg) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_acc_r <= acc_nxt;
      out_deg_r <= dv_side.deg;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_acc_r;
  assign out_tuser  = {out_sat_r, out_deg_r};

  // a zero-d beat carries a zero command and no clip
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("degenerate beat with nonzero command");

  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_vld_r)
    else $error("accepted beat lost at stage 1");

  // a stalled output beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // a beat leaving the square root enters stage A when the pipeline advances
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    en && sq_vld |=> sa_vld_r)
    else $error("square root beat lost");

endmodule

>>> test/tb_time_optimal_tracking_fhan.sv
// Testbench for the fhan tracking pipeline: random and corner beats checked against a predictor.
module tb_time_optimal_tracking_fhan import tof_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] accel;
    logic        deg;
    logic        sat;
  } fhan_res_t;

  // exact model of the fhan arithmetic at the block's widths
  function automatic fhan_res_t fhan_predict(logic [23:0] h, logic signed [31:0] x1,
                                             logic signed [31:0] x2, logic [30:0] r);
    fhan_res_t res;
    logic [127:0] prod, rad;
    logic [63:0] d, a0m, ym, am, root, cand, half, q;
    logic signed [63:0] a0, y, a2, a, fh;
    logic [63:0] hh;
    integer b;
    hh = {40'd0, h} * {40'd0, h};
    prod = {97'd0, r} * {64'd0, hh};
    d = prod[95:32];
    res.accel = 32'd0; res.deg = 1'b0; res.sat = 1'b0;
    if (d == 0) begin
      res.deg = 1'b1;
      return res;
    end
    a0m = ({40'd0, h} * (x2 < 0 ? 64'(-64'sd1 * x2) : 64'(x2))) >> 8;
    a0 = x2 < 0 ? -$signed(a0m) : $signed(a0m);
    y = ($signed(64'(x1)) <<< 16) + a0;
    ym = y < 0 ? 64'(-y) : 64'(y);
    rad = {64'd0, d} * {64'd0, d + 8 * ym};
    root = 0;
    for (b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= rad) root = cand;
    end
    half = (root - d) >> 1;
    a2 = a0 + (y > 0 ? $signed(half) : (y < 0 ? -$signed(half) : 64'sd0));
    a = (ym < d) ? a0 + y : a2;
    am = a < 0 ? 64'(-a) : 64'(a);
    if (am < d) begin
      q = 64'(({97'd0, r} * {64'd0, am}) / {64'd0, d});
      if (q > 64'h80000000) q = 64'h80000000;
      fh = a > 0 ? -$signed(q) : $signed(q);
    end else begin
      fh = a > 0 ? -$signed(64'(r)) : $signed(64'(r));
    end
    if (fh > 64'sd2147483647) begin
      fh = 64'sd2147483647; res.sat = 1'b1;
    end else if (fh < -64'sd2147483648) begin
      fh = -64'sd2147483648; res.sat = 1'b1;
    end
    res.accel = fh[31:0];
    return res;
  endfunction

  // in-order store of expected accel commands and flags
  class fhan_scoreboard;
    fhan_res_t pending[$];
    int errors;
    function void note_input(logic [23:0] h, logic [95:0] beat);
      pending.push_back(fhan_predict(h, beat[31:0], beat[63:32], beat[94:64]));
    endfunction
    function void check_result(logic [31:0] accel, logic [1:0] flags);
      fhan_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat accel=%h", accel);
        return;
      end
      e = pending.pop_front();
      if (e.accel !== accel || e.deg !== flags[0] || e.sat !== flags[1]) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp accel=%h deg=%b sat=%b got accel=%h deg=%b sat=%b",
                   e.accel, e.deg, e.sat, accel, flags[0], flags[1]);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_wr_en = 0;
  logic [23:0] cfg_wr_data = '0;
  logic in_tvalid = 0, in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;

  fhan_scoreboard sb = new();
  logic [23:0] step_h = STEP_RESET;
  int stall_mode = 0;

  always #6 clk = ~clk;

  time_optimal_tracking_fhan dut (.*);

  // receiver: stall pattern changes by phase
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // push one beat and hold it until it is accepted
  task automatic send_beat(logic [31:0] x1, logic [31:0] x2, logic [30:0] r);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, r, x2, x1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(step_h, {1'b0, r, x2, x1});
  endtask

  task automatic idle(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drain then write the step register
  task automatic set_step(logic [23:0] h);
    idle(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_h = h;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_err();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [30:0] rnd_speed();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 4));
      default: return 31'($urandom_range(1, 1 << 24));
    endcase
  endfunction

  initial begin
    logic [23:0] steps[6];
    int left;
    steps = '{24'd1, 24'hffffff, 24'd838861, 24'd4096, 24'd0, 24'h123456};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners at the reset step
    send_beat(32'd0, 32'd0, 31'd0);
    send_beat(32'd0, 32'd0, 31'h7fffffff);
    send_beat(32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    send_beat(32'h80000000, 32'h80000000, 31'h7fffffff);
    send_beat(32'h7fffffff, 32'h80000000, 31'd65536);
    send_beat(32'h80000000, 32'h7fffffff, 31'd1);
    send_beat(32'd1, 32'hffffffff, 31'd65536);
    send_beat(32'hffffffff, 32'd0, 31'd65536);
    send_beat(32'd0, 32'd65536, 31'd655360);
    send_beat(32'd0, 32'hffff0000, 31'd655360);
    send_beat(32'hffffffff, 32'hffffffff, 31'h55555555);
    idle(1);
    // random phases, each at one step setting
    foreach (steps[i]) begin
      set_step(steps[i]);
      stall_mode = i % 3;
      left = 315;
      while (left > 0) begin
        for (int k = $urandom_range(1, 20); k > 0 && left > 0; k--) begin
          send_beat(rnd_err(), rnd_err(), rnd_speed());
          left--;
        end
        if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
      end
      idle(1);
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_time_optimal_tracking_fhan passed");
    else
      $display("tb_time_optimal_tracking_fhan failed");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_time_optimal_tracking_fhan failed");
    $finish;
  end
endmodule
